// File: src/tlbpt_pkg.sv
// Shared constants for the TLB and page table address translator.
package tlbpt_pkg;

    localparam int VADDR_W     = 16;  // virtual address width
    localparam int PADDR_W     = 16;  // physical address width
    localparam int CNT_W       = 32;  // translation and hit counters
    localparam int FAULT_CNT_W = 9;   // page fault counter
    localparam int M_TUSER_W   = 2;   // tlb_hit, page_fault

    // Result word: physical address, translation count, hit count, fault count
    localparam int M_FIELDS_W  = PADDR_W + CNT_W + CNT_W + FAULT_CNT_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    // Flag positions within m_tuser
    localparam int TUSER_HIT   = 0;
    localparam int TUSER_FAULT = 1;

endpackage

// File: src/tlbpt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module tlbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/tlbpt_cam.sv
// TLB tag store: parallel page search, FIFO fill pointer and occupancy count.
module tlbpt_cam #(
    parameter int ENTRIES = 16,
    parameter int TAG_W   = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [TAG_W-1:0]           lookup_tag,
    output logic                       hit,
    output logic [$clog2(ENTRIES)-1:0] hit_index,
    input  logic                       wr_en,
    input  logic [TAG_W-1:0]           wr_tag,
    output logic [$clog2(ENTRIES)-1:0] fill_index
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int OCC_W = $clog2(ENTRIES + 1);

    logic [TAG_W-1:0] tag_reg [ENTRIES];
    logic [IDX_W-1:0] fill_ptr_reg, fill_ptr_next;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic [ENTRIES-1:0] match;
    logic [IDX_W-1:0] hit_index_c;

    // A page is only inserted after missing, so at most one slot matches.
    always_comb begin
        hit_index_c = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = (OCC_W'(i) < occ_reg) && (tag_reg[i] == lookup_tag);
            if (match[i]) begin
                hit_index_c = hit_index_c | IDX_W'(i);
            end
        end
    end

    assign hit        = |match;
    assign hit_index  = hit_index_c;
    assign fill_index = fill_ptr_reg;

    always_comb begin
        fill_ptr_next = fill_ptr_reg;
        occ_next      = occ_reg;
        if (wr_en) begin
            if (fill_ptr_reg == IDX_W'(ENTRIES - 1)) begin
                fill_ptr_next = '0;
            end else begin
                fill_ptr_next = fill_ptr_reg + 1'b1;
            end
            if (occ_reg < OCC_W'(ENTRIES)) begin
                occ_next = occ_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_ptr_reg <= '0;
            occ_reg      <= '0;
        end else begin
            fill_ptr_reg <= fill_ptr_next;
            occ_reg      <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tag_reg[fill_ptr_reg] <= wr_tag;
        end
    end

endmodule

// File: src/tlb_page_table_translator_core.sv
// Virtual to physical address translator: TLB search with FIFO refill, backed by a page table.
// Each transfer on the s_ side carries one virtual address; each transfer on the m_ side
// carries its translation. In the accept cycle the TLB tags are searched in parallel and
// both memories (TLB frames, page table) are read; in S_RESOLVE, once the output is free, the
// registered read data resolves the frame, any page fault writes the page table, a TLB
// miss refills the slot at the FIFO pointer, and the result loads the output register. A new
// address is taken while a finished result is still waiting on m_tready. After reset the page
// table is swept to invalid, one entry per cycle, over all PAGE_COUNT entries while s_tready
// stays low. PAGE_COUNT must be a power of two; frames are allocated sequentially and wrap at
// PAGE_COUNT.
module tlb_page_table_translator_core
    import tlbpt_pkg::*;
#(
    parameter int TLB_ENTRIES  = 16,
    parameter int PAGE_COUNT   = 256,
    parameter int OFFSET_WIDTH = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // s_tdata[15:0]: virtual_address
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [VADDR_W-1:0]   s_tdata,
    // m_tdata[15:0]: phys_addr, [47:16]: translation_count, [79:48]: hit_count,
    // [88:80]: fault_count, upper bits zero
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    // m_tuser[0]: tlb_hit, [1]: page_fault
    output logic [M_TUSER_W-1:0] m_tuser
);

    localparam int PAGE_W = $clog2(PAGE_COUNT);
    localparam int IDX_W  = $clog2(TLB_ENTRIES);
    localparam int PTE_W  = PAGE_W + 1;   // valid bit above the frame number

    localparam logic [1:0] S_CLEAR   = 2'd0;
    localparam logic [1:0] S_IDLE    = 2'd1;
    localparam logic [1:0] S_RESOLVE = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [PAGE_W-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [PAGE_W-1:0]       page_reg;
    logic [OFFSET_WIDTH-1:0] offset_reg;
    logic                    hit_reg;
    logic [PAGE_W-1:0]       next_free_reg, next_free_next;
    logic [CNT_W-1:0]        trans_cnt_reg, trans_cnt_next;
    logic [CNT_W-1:0]        hit_cnt_reg, hit_cnt_next;
    logic [FAULT_CNT_W-1:0]  fault_cnt_reg, fault_cnt_next;
    logic                    m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]    m_data_reg;
    logic [M_TUSER_W-1:0]    m_user_reg;

    logic                    s_fire;
    logic                    resolve_fire;
    logic [PAGE_W-1:0]       page_in;
    logic [OFFSET_WIDTH-1:0] offset_in;
    logic [31:0]             va_shifted;
    logic                    cam_hit;
    logic [IDX_W-1:0]        cam_hit_index;
    logic [IDX_W-1:0]        cam_fill_index;
    logic [PAGE_W-1:0]       tlb_frame_rd;
    logic [PTE_W-1:0]        pte_rd;
    logic                    fault;
    logic [PAGE_W-1:0]       frame;
    logic [31:0]             pa_wide;
    logic                    pt_we;
    logic [PAGE_W-1:0]       pt_waddr;
    logic [PTE_W-1:0]        pt_wdata;
    logic                    tlb_we;

    // Page number reduced to the table size, offset from the low bits
    assign va_shifted = 32'(s_tdata) >> OFFSET_WIDTH;
    assign page_in    = va_shifted[PAGE_W-1:0];
    assign offset_in  = OFFSET_WIDTH'(s_tdata);

    assign s_tready     = (state_reg == S_IDLE);
    assign s_fire       = s_tvalid && s_tready;
    assign resolve_fire = (state_reg == S_RESOLVE) && (!m_valid_reg || m_tready);

    tlbpt_cam #(
        .ENTRIES (TLB_ENTRIES),
        .TAG_W   (PAGE_W)
    ) u_cam (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .lookup_tag (page_in),
        .hit        (cam_hit),
        .hit_index  (cam_hit_index),
        .wr_en      (tlb_we),
        .wr_tag     (page_reg),
        .fill_index (cam_fill_index)
    );

    tlbpt_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (TLB_ENTRIES)
    ) u_tlb_frame_ram (
        .aclk  (aclk),
        .we    (tlb_we),
        .waddr (cam_fill_index),
        .wdata (frame),
        .re    (s_fire),
        .raddr (cam_hit_index),
        .rdata (tlb_frame_rd)
    );

    tlbpt_ram #(
        .WIDTH (PTE_W),
        .DEPTH (PAGE_COUNT)
    ) u_page_table_ram (
        .aclk  (aclk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata (pt_wdata),
        .re    (s_fire),
        .raddr (page_in),
        .rdata (pte_rd)
    );

    // Frame resolution from the registered read data
    assign fault   = !hit_reg && !pte_rd[PTE_W-1];
    assign pa_wide = (32'(frame) << OFFSET_WIDTH) | 32'(offset_reg);
    assign tlb_we  = resolve_fire && !hit_reg;

    always_comb begin
        priority if (hit_reg) begin
            frame = tlb_frame_rd;
        end else if (pte_rd[PTE_W-1]) begin
            frame = pte_rd[PAGE_W-1:0];
        end else begin
            frame = next_free_reg;
        end
    end

    // Page table port: clearing sweep after reset, otherwise fault allocation
    always_comb begin
        if (state_reg == S_CLEAR) begin
            pt_we    = 1'b1;
            pt_waddr = clr_cnt_reg;
            pt_wdata = '0;
        end else begin
            pt_we    = resolve_fire && fault;
            pt_waddr = page_reg;
            pt_wdata = {1'b1, next_free_reg};
        end
    end

    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        next_free_next = next_free_reg;
        trans_cnt_next = trans_cnt_reg;
        hit_cnt_next   = hit_cnt_reg;
        fault_cnt_next = fault_cnt_reg;
        m_valid_next   = m_valid_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == PAGE_W'(PAGE_COUNT - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_fire) begin
                    state_next = S_RESOLVE;
                end
            end
            S_RESOLVE: begin
                if (resolve_fire) begin
                    state_next     = S_IDLE;
                    m_valid_next   = 1'b1;
                    trans_cnt_next = trans_cnt_reg + 1'b1;
                    if (hit_reg) begin
                        hit_cnt_next = hit_cnt_reg + 1'b1;
                    end
                    if (fault) begin
                        next_free_next = next_free_reg + 1'b1;
                        fault_cnt_next = fault_cnt_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            next_free_reg <= '0;
            trans_cnt_reg <= '0;
            hit_cnt_reg   <= '0;
            fault_cnt_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            next_free_reg <= next_free_next;
            trans_cnt_reg <= trans_cnt_next;
            hit_cnt_reg   <= hit_cnt_next;
            fault_cnt_reg <= fault_cnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            page_reg   <= page_in;
            offset_reg <= offset_in;
            hit_reg    <= cam_hit;
        end
        if (resolve_fire) begin
            m_data_reg <= M_TDATA_W'({fault_cnt_next, hit_cnt_next, trans_cnt_next,
                                      pa_wide[PADDR_W-1:0]});
            m_user_reg[TUSER_HIT]   <= hit_reg;
            m_user_reg[TUSER_FAULT] <= fault;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// File: dv/tb_tlb_page_table_translator_core.sv
// Self-checking testbench for the TLB and page table address translator core.
module tb_tlb_page_table_translator_core;
    import tlbpt_pkg::*;

    localparam int TLB_SLOTS    = 16;
    localparam int PAGES        = 256;
    localparam int OFF_W        = 8;
    localparam int PAGE_W       = $clog2(PAGES);
    localparam int ITEMS        = 600;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int RECENT_DEPTH = 24;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [VADDR_W-1:0]   s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // Mirror of the translator: TLB, page table and counters, plus pending translations
    class xlat_scoreboard;
        typedef struct packed {
            logic [PADDR_W-1:0]     paddr;
            logic                   hit;
            logic                   fault;
            logic [CNT_W-1:0]       n_xlat;
            logic [CNT_W-1:0]       n_hit;
            logic [FAULT_CNT_W-1:0] n_fault;
        } xlat_t;

        xlat_t                  expected_q[$];
        logic [PAGE_W-1:0]      slot_page[TLB_SLOTS];
        logic [PAGE_W-1:0]      slot_frame[TLB_SLOTS];
        int                     fill_ptr;
        int                     valid_slots;
        bit                     pte_valid[PAGES];
        logic [PAGE_W-1:0]      pte_frame[PAGES];
        logic [PAGE_W-1:0]      next_frame;
        logic [CNT_W-1:0]       n_xlat;
        logic [CNT_W-1:0]       n_hit;
        logic [FAULT_CNT_W-1:0] n_fault;
        int                     errors;

        function new();
            fill_ptr    = 0;
            valid_slots = 0;
            next_frame  = '0;
            n_xlat      = '0;
            n_hit       = '0;
            n_fault     = '0;
            errors      = 0;
            foreach (pte_valid[i]) begin
                pte_valid[i] = 1'b0;
                pte_frame[i] = '0;
            end
        endfunction

        function void note_address(logic [VADDR_W-1:0] va);
            logic [PAGE_W-1:0] page;
            logic [OFF_W-1:0]  offset;
            logic [PAGE_W-1:0] frame;
            logic              hit;
            logic              fault;
            xlat_t             e;
            offset = va[OFF_W-1:0];
            page   = PAGE_W'(va >> OFF_W);
            frame  = '0;
            hit    = 1'b0;
            fault  = 1'b0;
            n_xlat = n_xlat + 1;
            // only filled slots are searched; last match wins
            for (int i = 0; i < valid_slots; i++) begin
                if (slot_page[i] == page) begin
                    frame = slot_frame[i];
                    hit   = 1'b1;
                end
            end
            if (hit) begin
                n_hit = n_hit + 1;
            end else begin
                if (pte_valid[page]) begin
                    frame = pte_frame[page];
                end else begin
                    fault           = 1'b1;
                    frame           = next_frame;
                    next_frame      = next_frame + 1;
                    pte_valid[page] = 1'b1;
                    pte_frame[page] = frame;
                    n_fault         = n_fault + 1;
                end
                slot_page[fill_ptr]  = page;
                slot_frame[fill_ptr] = frame;
                fill_ptr             = (fill_ptr + 1) % TLB_SLOTS;
                if (valid_slots < TLB_SLOTS)
                    valid_slots++;
            end
            e.paddr   = PADDR_W'((32'(frame) << OFF_W) | 32'(offset));
            e.hit     = hit;
            e.fault   = fault;
            e.n_xlat  = n_xlat;
            e.n_hit   = n_hit;
            e.n_fault = n_fault;
            expected_q.push_back(e);
        endfunction

        function void check_field(string name, logic [CNT_W-1:0] exp_v, logic [CNT_W-1:0] act_v);
            if (act_v !== exp_v) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data, logic [M_TUSER_W-1:0] user);
            xlat_t e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result transfer, expected none, actual tdata %0h",
                         $time, data);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            check_field("phys_addr", e.paddr, data[PADDR_W-1:0]);
            check_field("translation_count", e.n_xlat, data[PADDR_W +: CNT_W]);
            check_field("hit_count", e.n_hit, data[PADDR_W+CNT_W +: CNT_W]);
            check_field("fault_count", e.n_fault, data[PADDR_W+2*CNT_W +: FAULT_CNT_W]);
            check_field("tdata padding", '0, data[M_TDATA_W-1:M_FIELDS_W]);
            check_field("tlb_hit", e.hit, user[TUSER_HIT]);
            check_field("page_fault", e.fault, user[TUSER_FAULT]);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    xlat_scoreboard      sb;
    bit                  hold_off_req;
    bit                  gaps_on;
    logic [PAGE_W-1:0]   sweep_page;
    logic [PAGE_W-1:0]   recent_pages[$];
    logic [VADDR_W-1:0]  directed_va[$];

    tlb_page_table_translator_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Recent pages (TLB hits and refills), a sweep to fault every page, some noise
    function automatic logic [VADDR_W-1:0] pick_address();
        int                r;
        logic [PAGE_W-1:0] page;
        r = $urandom_range(0, 99);
        if (r < 40 && recent_pages.size() > 0) begin
            page = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
        end else if (r < 80) begin
            page       = sweep_page;
            sweep_page = sweep_page + 1;
        end else begin
            page = PAGE_W'($urandom_range(0, PAGES - 1));
        end
        return {page, OFF_W'($urandom_range(0, (1 << OFF_W) - 1))};
    endfunction

    task automatic send_address(input logic [VADDR_W-1:0] va);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= va;
        do
            @(posedge aclk);
        while (!s_tready);
        sb.note_address(va);
        recent_pages.push_back(PAGE_W'(va >> OFF_W));
        if (recent_pages.size() > RECENT_DEPTH)
            void'(recent_pages.pop_front());
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // stop offering and wait for every outstanding translation
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    // receiver: random back-pressure, long holds on request
    initial begin
        int len;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                len = $urandom_range(0, 99);
                if (len < 25) begin
                    m_tready <= 1'b0;
                    len = (len < 22) ? $urandom_range(1, 3) : $urandom_range(10, 40);
                end else begin
                    m_tready <= 1'b1;
                    len = (len < 90) ? $urandom_range(1, 12) : $urandom_range(50, 100);
                end
                repeat (len) begin
                    @(posedge aclk);
                    if (hold_off_req)
                        break;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    initial begin
        sb           = new();
        hold_off_req = 1'b0;
        gaps_on      = 1'b0;
        sweep_page   = '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        aresetn  <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // extremes, hit after fault, TLB wrap-round, refill from page table without a fault
        directed_va = '{16'h0000, 16'h00FF, 16'hFFFF, 16'hFF00, 16'hAA55, 16'h55AA};
        for (int p = 1; p <= 12; p++)
            directed_va.push_back({PAGE_W'(p), (p % 2) ? 8'hFF : 8'h00});
        directed_va.push_back(16'h0D3C);  // evicts page 0
        directed_va.push_back(16'h0081);  // page 0 back from the page table
        directed_va.push_back(16'hFF7E);
        directed_va.push_back(16'h8001);
        foreach (directed_va[i])
            send_address(directed_va[i]);

        // receiver holds off while the sender keeps offering
        hold_off_req = 1'b1;
        repeat (20) send_address(pick_address());
        drain_results();

        for (int n = 0; n < ITEMS; n++) begin
            if (n % 50 == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            if (n == ITEMS / 2)
                drain_results();
            send_address(pick_address());
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

endmodule
